/* design/pfa_pkg.sv */
`timescale 1ns / 1ps
// Paged frame allocator package: request and response payloads, action and
// status codes, sequencer states. No dependencies.
package pfa_pkg;

  localparam int NUM_FRAMES_DEF = 64;
  localparam int MAX_PROCS_DEF  = 16;
  localparam int PS_W           = 13;
  localparam int DIV_W          = 20;
  localparam int PAGE_LIMIT     = 64;
  localparam logic [PS_W-1:0] PS_RESET = 13'd32;

  localparam logic [2:0] ACT_CREATE    = 3'd0;
  localparam logic [2:0] ACT_RESIZE    = 3'd1;
  localparam logic [2:0] ACT_RELEASE   = 3'd2;
  localparam logic [2:0] ACT_TRANSLATE = 3'd3;
  localparam logic [2:0] ACT_CHECK     = 3'd4;

  localparam logic [2:0] STAT_OK         = 3'd0;
  localparam logic [2:0] STAT_NO_FRAME   = 3'd1;
  localparam logic [2:0] STAT_NO_PROC    = 3'd2;
  localparam logic [2:0] STAT_DENIED     = 3'd3;
  localparam logic [2:0] STAT_TABLE_FULL = 3'd4;

  typedef struct packed {
    logic [2:0]  action;
    logic [15:0] pid;
    logic [5:0]  page;
    logic [18:0] new_size;
    logic [17:0] address;
    logic [18:0] length;
  } req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [5:0]  frame;
    logic [17:0] base_address;
    logic [6:0]  page_count;
  } rsp_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PSCAN,
    ST_DISPATCH,
    ST_DIV,
    ST_RESIZE,
    ST_CK_START,
    ST_FSCAN,
    ST_CK_RD,
    ST_CK_EV1,
    ST_CK_WAIT,
    ST_CK_EV2,
    ST_BASE1,
    ST_BASE2,
    ST_DONE
  } state_t;

  typedef enum logic [2:0] {
    SM_FIRST_FREE,
    SM_COUNT,
    SM_ALLOC,
    SM_SHRINK,
    SM_RELEASE,
    SM_XLATE
  } scan_mode_t;

endpackage

/* design/paged_frame_allocator.sv */
`timescale 1ns / 1ps
// Paged frame allocator top level: sequencer, frame bitmap, owner/page and
// process memories, shared restoring divider and multiplier. Uses pfa_pkg.
//
// Usage: requests enter on in_valid/in_ready with an in_data payload of type
// pfa_pkg::req_t; one response per request leaves on out_valid/out_ready as
// pfa_pkg::rsp_t. page_size is written through cfg_we/cfg_wdata while idle.
// in_ready is high only while the sequencer is idle; one request at a time.
// Steps per request, from acceptance to out_valid: a process table scan, then
//   create/translate: one frame scan, then the base multiply
//   release: one frame scan
//   resize: divider + up to two frame scans (count, then allocate)
//   check: divider, owner and length checks, then the base multiply
// The frame scans and the bit-serial divider take most of the time.
// Reset (synchronous, rst_n low) frees every frame, empties the process
// table and sets page_size to 32. A stalled receiver holds the response in
// the output register; the next request is taken meanwhile and its response
// waits in the sequencer until the output register drains.
module paged_frame_allocator #(
  parameter int NUM_FRAMES = pfa_pkg::NUM_FRAMES_DEF,
  parameter int MAX_PROCS  = pfa_pkg::MAX_PROCS_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  pfa_pkg::req_t             in_data,
  output logic                      out_valid,
  input  logic                      out_ready,
  output pfa_pkg::rsp_t             out_data,
  input  logic                      cfg_we,
  input  logic [pfa_pkg::PS_W-1:0]  cfg_wdata
);

  localparam int FW = $clog2(NUM_FRAMES);
  localparam int PW = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
  localparam int MA = (FW > 7) ? FW : 7;
  localparam int CW = MA + pfa_pkg::PS_W;
  localparam int DW = pfa_pkg::DIV_W;
  localparam int SW = pfa_pkg::PS_W;

  pfa_pkg::state_t     state_r, state_nxt;
  pfa_pkg::scan_mode_t mode_r, mode_nxt;
  pfa_pkg::req_t       req_r, req_nxt;
  pfa_pkg::rsp_t       res_r, res_nxt;
  pfa_pkg::rsp_t       out_r, out_nxt;
  logic                out_valid_r, out_valid_nxt;

  logic [SW-1:0] ps_cfg_r, ps_cfg_nxt;
  logic [SW-1:0] ps_r, ps_nxt;

  logic          found_r, found_nxt;
  logic [PW-1:0] p_r, p_nxt;
  logic [6:0]    cur_r, cur_nxt;
  logic          slot_found_r, slot_found_nxt;
  logic [PW-1:0] slot_r, slot_nxt;
  logic [PW-1:0] pa_r, pa_nxt;
  logic          prd_vld_r, prd_vld_nxt;
  logic [PW-1:0] prd_idx_r, prd_idx_nxt;
  logic [15:0]   pid_rd_r;
  logic [6:0]    pages_rd_r;

  logic [FW-1:0] fi_r, fi_nxt;
  logic          frd_vld_r, frd_vld_nxt;
  logic [FW-1:0] frd_idx_r, frd_idx_nxt;
  logic [15:0]   ow_rd_r;
  logic [5:0]    pg_rd_r;

  logic [NUM_FRAMES-1:0] frame_used_r, frame_used_nxt;
  logic [MAX_PROCS-1:0]  proc_valid_r, proc_valid_nxt;

  logic [DW-1:0] dq_r, dq_nxt;
  logic [SW-1:0] drem_r, drem_nxt;
  logic [4:0]    dcnt_r, dcnt_nxt;

  logic [MA-1:0] mul_a_r, mul_a_nxt;
  logic [CW-1:0] prod_r;

  logic [6:0]    want_r, want_nxt;
  logic [6:0]    need_r, need_nxt;
  logic [6:0]    k_r, k_nxt;
  logic [FW:0]   freec_r, freec_nxt;
  logic [FW-1:0] hit_idx_r, hit_idx_nxt;

  logic [15:0] frame_owner_mem [NUM_FRAMES];
  logic [5:0]  frame_page_mem  [NUM_FRAMES];
  logic [15:0] proc_id_mem     [MAX_PROCS];
  logic [6:0]  proc_pages_mem  [MAX_PROCS];

  logic          fwe;
  logic [FW-1:0] fwa;
  logic [5:0]    fw_page;
  logic          pwe;
  logic [PW-1:0] pwa;
  logic [6:0]    pw_pages;

  logic [SW:0]   div_sh;
  logic          div_ge;
  logic [SW:0]   div_sub;
  logic          f_used, f_own, f_last;
  logic          ck_own;
  logic [SW:0]   avail;
  logic [CW-1:0] len_x, avail_x, diff_x;
  logic [FW:0]   free_tot;
  logic [DW-1:0] rs_dividend;

  assign in_ready  = (state_r == pfa_pkg::ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  assign div_sh   = {drem_r, dq_r[DW-1]};
  assign div_ge   = div_sh >= {1'b0, ps_r};
  assign div_sub  = div_sh - {1'b0, ps_r};
  assign f_used   = frame_used_r[frd_idx_r];
  assign f_own    = f_used && (ow_rd_r == req_r.pid);
  assign f_last   = (frd_idx_r == FW'(NUM_FRAMES - 1));
  assign ck_own   = frame_used_r[hit_idx_r] && (ow_rd_r == req_r.pid);
  assign avail    = {1'b0, ps_r} - {1'b0, drem_r};
  assign len_x    = CW'(req_r.length);
  assign avail_x  = CW'(avail);
  assign diff_x   = len_x - avail_x;
  assign free_tot = freec_r + {{FW{1'b0}}, ~f_used};
  assign rs_dividend = DW'(req_r.new_size) + DW'(ps_r) - DW'(1);

  always_ff @(posedge clk) begin
    if (fwe) begin
      frame_owner_mem[fwa] <= req_r.pid;
      frame_page_mem[fwa]  <= fw_page;
    end
    ow_rd_r <= frame_owner_mem[fi_r];
    pg_rd_r <= frame_page_mem[fi_r];
  end

  always_ff @(posedge clk) begin
    if (pwe) begin
      proc_id_mem[pwa]    <= req_r.pid;
      proc_pages_mem[pwa] <= pw_pages;
    end
    pid_rd_r   <= proc_id_mem[pa_r];
    pages_rd_r <= proc_pages_mem[pa_r];
  end

  always_ff @(posedge clk) begin
    prod_r <= CW'(mul_a_r) * CW'(ps_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= pfa_pkg::ST_IDLE;
      out_valid_r  <= 1'b0;
      ps_cfg_r     <= pfa_pkg::PS_RESET;
      frame_used_r <= '0;
      proc_valid_r <= '0;
      prd_vld_r    <= 1'b0;
      frd_vld_r    <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      out_valid_r  <= out_valid_nxt;
      ps_cfg_r     <= ps_cfg_nxt;
      frame_used_r <= frame_used_nxt;
      proc_valid_r <= proc_valid_nxt;
      prd_vld_r    <= prd_vld_nxt;
      frd_vld_r    <= frd_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mode_r       <= mode_nxt;
    req_r        <= req_nxt;
    res_r        <= res_nxt;
    out_r        <= out_nxt;
    ps_r         <= ps_nxt;
    found_r      <= found_nxt;
    p_r          <= p_nxt;
    cur_r        <= cur_nxt;
    slot_found_r <= slot_found_nxt;
    slot_r       <= slot_nxt;
    pa_r         <= pa_nxt;
    prd_idx_r    <= prd_idx_nxt;
    fi_r         <= fi_nxt;
    frd_idx_r    <= frd_idx_nxt;
    dq_r         <= dq_nxt;
    drem_r       <= drem_nxt;
    dcnt_r       <= dcnt_nxt;
    mul_a_r      <= mul_a_nxt;
    want_r       <= want_nxt;
    need_r       <= need_nxt;
    k_r          <= k_nxt;
    freec_r      <= freec_nxt;
    hit_idx_r    <= hit_idx_nxt;
  end

  always_comb begin
    state_nxt      = state_r;
    mode_nxt       = mode_r;
    req_nxt        = req_r;
    res_nxt        = res_r;
    out_nxt        = out_r;
    out_valid_nxt  = out_valid_r;
    ps_cfg_nxt     = ps_cfg_r;
    ps_nxt         = ps_r;
    found_nxt      = found_r;
    p_nxt          = p_r;
    cur_nxt        = cur_r;
    slot_found_nxt = slot_found_r;
    slot_nxt       = slot_r;
    pa_nxt         = pa_r;
    prd_vld_nxt    = 1'b0;
    prd_idx_nxt    = prd_idx_r;
    fi_nxt         = fi_r;
    frd_vld_nxt    = 1'b0;
    frd_idx_nxt    = frd_idx_r;
    frame_used_nxt = frame_used_r;
    proc_valid_nxt = proc_valid_r;
    dq_nxt         = dq_r;
    drem_nxt       = drem_r;
    dcnt_nxt       = dcnt_r;
    mul_a_nxt      = mul_a_r;
    want_nxt       = want_r;
    need_nxt       = need_r;
    k_nxt          = k_r;
    freec_nxt      = freec_r;
    hit_idx_nxt    = hit_idx_r;
    fwe            = 1'b0;
    fwa            = frd_idx_r;
    fw_page        = '0;
    pwe            = 1'b0;
    pwa            = p_r;
    pw_pages       = want_r;

    if (cfg_we) begin
      ps_cfg_nxt = cfg_wdata;
    end
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      pfa_pkg::ST_IDLE: begin
        if (in_valid) begin
          req_nxt        = in_data;
          ps_nxt         = (ps_cfg_r == '0) ? SW'(1) : ps_cfg_r;
          found_nxt      = 1'b0;
          slot_found_nxt = 1'b0;
          cur_nxt        = '0;
          pa_nxt         = '0;
          state_nxt      = pfa_pkg::ST_PSCAN;
        end
      end
      pfa_pkg::ST_PSCAN: begin
        pa_nxt      = pa_r + PW'(1);
        prd_vld_nxt = 1'b1;
        prd_idx_nxt = pa_r;
        if (prd_vld_r) begin
          if (proc_valid_r[prd_idx_r] && (pid_rd_r == req_r.pid) && !found_r) begin
            found_nxt = 1'b1;
            p_nxt     = prd_idx_r;
            cur_nxt   = pages_rd_r;
          end
          if (!proc_valid_r[prd_idx_r] && !slot_found_r) begin
            slot_found_nxt = 1'b1;
            slot_nxt       = prd_idx_r;
          end
          if (prd_idx_r == PW'(MAX_PROCS - 1)) begin
            prd_vld_nxt = 1'b0;
            state_nxt   = pfa_pkg::ST_DISPATCH;
          end
        end
      end
      pfa_pkg::ST_DISPATCH: begin
        res_nxt     = '0;
        fi_nxt      = '0;
        freec_nxt   = '0;
        k_nxt       = '0;
        dcnt_nxt    = '0;
        drem_nxt    = '0;
        state_nxt   = pfa_pkg::ST_DONE;
        if (req_r.action == pfa_pkg::ACT_CREATE) begin
          if (found_r) begin
            res_nxt.status     = pfa_pkg::STAT_DENIED;
            res_nxt.page_count = cur_r;
          end else if (!slot_found_r) begin
            res_nxt.status = pfa_pkg::STAT_TABLE_FULL;
          end else begin
            mode_nxt  = pfa_pkg::SM_FIRST_FREE;
            state_nxt = pfa_pkg::ST_FSCAN;
          end
        end else if (req_r.action > pfa_pkg::ACT_CHECK) begin
          res_nxt.status = pfa_pkg::STAT_DENIED;
        end else if (!found_r) begin
          res_nxt.status = pfa_pkg::STAT_NO_PROC;
        end else begin
          res_nxt.page_count = cur_r;
          case (req_r.action)
            pfa_pkg::ACT_RESIZE: begin
              dq_nxt    = rs_dividend;
              state_nxt = pfa_pkg::ST_DIV;
            end
            pfa_pkg::ACT_RELEASE: begin
              mode_nxt  = pfa_pkg::SM_RELEASE;
              state_nxt = pfa_pkg::ST_FSCAN;
            end
            pfa_pkg::ACT_TRANSLATE: begin
              if ({1'b0, req_r.page} < cur_r) begin
                mode_nxt  = pfa_pkg::SM_XLATE;
                state_nxt = pfa_pkg::ST_FSCAN;
              end else begin
                res_nxt.status = pfa_pkg::STAT_DENIED;
              end
            end
            default: begin
              dq_nxt    = DW'(req_r.address);
              state_nxt = pfa_pkg::ST_DIV;
            end
          endcase
        end
      end
      pfa_pkg::ST_DIV: begin
        dq_nxt   = {dq_r[DW-2:0], div_ge};
        drem_nxt = div_ge ? div_sub[SW-1:0] : div_sh[SW-1:0];
        dcnt_nxt = dcnt_r + 5'd1;
        if (dcnt_r == 5'(DW - 1)) begin
          state_nxt = (req_r.action == pfa_pkg::ACT_RESIZE) ? pfa_pkg::ST_RESIZE
                                                             : pfa_pkg::ST_CK_START;
        end
      end
      pfa_pkg::ST_RESIZE: begin
        want_nxt  = dq_r[6:0];
        need_nxt  = dq_r[6:0] - cur_r;
        fi_nxt    = '0;
        state_nxt = pfa_pkg::ST_FSCAN;
        if (dq_r > DW'(pfa_pkg::PAGE_LIMIT)) begin
          res_nxt.status = pfa_pkg::STAT_NO_FRAME;
          state_nxt      = pfa_pkg::ST_DONE;
        end else if (dq_r[6:0] < cur_r) begin
          mode_nxt = pfa_pkg::SM_SHRINK;
        end else if (dq_r[6:0] > cur_r) begin
          mode_nxt = pfa_pkg::SM_COUNT;
        end else begin
          pwe                = 1'b1;
          pw_pages           = dq_r[6:0];
          res_nxt.page_count = dq_r[6:0];
          state_nxt          = pfa_pkg::ST_DONE;
        end
      end
      pfa_pkg::ST_CK_START: begin
        if (dq_r >= DW'(NUM_FRAMES)) begin
          res_nxt.status = pfa_pkg::STAT_DENIED;
          state_nxt      = pfa_pkg::ST_DONE;
        end else begin
          fi_nxt      = dq_r[FW-1:0];
          hit_idx_nxt = dq_r[FW-1:0];
          mul_a_nxt   = MA'(cur_r);
          state_nxt   = pfa_pkg::ST_CK_RD;
        end
      end
      pfa_pkg::ST_CK_RD: begin
        state_nxt = pfa_pkg::ST_CK_EV1;
      end
      pfa_pkg::ST_CK_EV1: begin
        if (!ck_own || (len_x > prod_r)) begin
          res_nxt.status = pfa_pkg::STAT_DENIED;
          state_nxt      = pfa_pkg::ST_DONE;
        end else if (len_x <= avail_x) begin
          mul_a_nxt = MA'(hit_idx_r);
          state_nxt = pfa_pkg::ST_BASE1;
        end else if ({1'b0, pg_rd_r} >= cur_r) begin
          res_nxt.status = pfa_pkg::STAT_DENIED;
          state_nxt      = pfa_pkg::ST_DONE;
        end else begin
          mul_a_nxt = MA'(cur_r - 7'd1 - {1'b0, pg_rd_r});
          state_nxt = pfa_pkg::ST_CK_WAIT;
        end
      end
      pfa_pkg::ST_CK_WAIT: begin
        state_nxt = pfa_pkg::ST_CK_EV2;
      end
      pfa_pkg::ST_CK_EV2: begin
        if (diff_x <= prod_r) begin
          mul_a_nxt = MA'(hit_idx_r);
          state_nxt = pfa_pkg::ST_BASE1;
        end else begin
          res_nxt.status = pfa_pkg::STAT_DENIED;
          state_nxt      = pfa_pkg::ST_DONE;
        end
      end
      pfa_pkg::ST_FSCAN: begin
        fi_nxt      = fi_r + FW'(1);
        frd_vld_nxt = 1'b1;
        frd_idx_nxt = fi_r;
        if (frd_vld_r) begin
          case (mode_r)
            pfa_pkg::SM_FIRST_FREE: begin
              if (!f_used) begin
                frame_used_nxt[frd_idx_r] = 1'b1;
                fwe                       = 1'b1;
                pwe                       = 1'b1;
                pwa                       = slot_r;
                pw_pages                  = 7'd1;
                proc_valid_nxt[slot_r]    = 1'b1;
                hit_idx_nxt               = frd_idx_r;
                mul_a_nxt                 = MA'(frd_idx_r);
                res_nxt.page_count        = 7'd1;
                frd_vld_nxt               = 1'b0;
                state_nxt                 = pfa_pkg::ST_BASE1;
              end else if (f_last) begin
                res_nxt.status = pfa_pkg::STAT_NO_FRAME;
                frd_vld_nxt    = 1'b0;
                state_nxt      = pfa_pkg::ST_DONE;
              end
            end
            pfa_pkg::SM_COUNT: begin
              freec_nxt = free_tot;
              if (f_last) begin
                frd_vld_nxt = 1'b0;
                fi_nxt      = '0;
                if (11'(need_r) > 11'(free_tot)) begin
                  res_nxt.status = pfa_pkg::STAT_NO_FRAME;
                  state_nxt      = pfa_pkg::ST_DONE;
                end else begin
                  mode_nxt = pfa_pkg::SM_ALLOC;
                end
              end
            end
            pfa_pkg::SM_ALLOC: begin
              if (!f_used) begin
                frame_used_nxt[frd_idx_r] = 1'b1;
                fwe                       = 1'b1;
                fw_page                   = 6'(cur_r + k_r);
                k_nxt                     = k_r + 7'd1;
                if (k_r + 7'd1 == need_r) begin
                  pwe                = 1'b1;
                  res_nxt.page_count = want_r;
                  frd_vld_nxt        = 1'b0;
                  state_nxt          = pfa_pkg::ST_DONE;
                end
              end
            end
            pfa_pkg::SM_SHRINK: begin
              if (f_own && ({1'b0, pg_rd_r} >= want_r)) begin
                frame_used_nxt[frd_idx_r] = 1'b0;
              end
              if (f_last) begin
                pwe                = 1'b1;
                res_nxt.page_count = want_r;
                frd_vld_nxt        = 1'b0;
                state_nxt          = pfa_pkg::ST_DONE;
              end
            end
            pfa_pkg::SM_RELEASE: begin
              if (f_own) begin
                frame_used_nxt[frd_idx_r] = 1'b0;
              end
              if (f_last) begin
                proc_valid_nxt[p_r] = 1'b0;
                res_nxt.page_count  = '0;
                frd_vld_nxt         = 1'b0;
                state_nxt           = pfa_pkg::ST_DONE;
              end
            end
            default: begin
              if (f_own && (pg_rd_r == req_r.page)) begin
                hit_idx_nxt = frd_idx_r;
                mul_a_nxt   = MA'(frd_idx_r);
                frd_vld_nxt = 1'b0;
                state_nxt   = pfa_pkg::ST_BASE1;
              end else if (f_last) begin
                res_nxt.status = pfa_pkg::STAT_DENIED;
                frd_vld_nxt    = 1'b0;
                state_nxt      = pfa_pkg::ST_DONE;
              end
            end
          endcase
        end
      end
      pfa_pkg::ST_BASE1: begin
        state_nxt = pfa_pkg::ST_BASE2;
      end
      pfa_pkg::ST_BASE2: begin
        res_nxt.status       = pfa_pkg::STAT_OK;
        res_nxt.frame        = 6'(hit_idx_r);
        res_nxt.base_address = prod_r[17:0];
        state_nxt            = pfa_pkg::ST_DONE;
      end
      pfa_pkg::ST_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_nxt       = res_r;
          state_nxt     = pfa_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = pfa_pkg::ST_IDLE;
      end
    endcase
  end

  a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == pfa_pkg::ST_DONE))
    else $error("response raised outside of completion");

  a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == pfa_pkg::ST_DIV) |-> (ps_r != '0))
    else $error("divider running with zero page size");

  a_alloc_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == pfa_pkg::ST_FSCAN && mode_r == pfa_pkg::SM_ALLOC) |-> (k_r < need_r))
    else $error("allocation count overran request");

  a_fail_no_frame: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.status != pfa_pkg::STAT_OK)
      |-> (out_r.frame == '0 && out_r.base_address == '0))
    else $error("failed response carries a frame");

endmodule
